>>> rtl/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg: shared definitions for the cluster link table allocator
// Table geometry, link markers, operation and status codes, register
// indexes and the structs passed between the allocator modules.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int TABLE_ENTRIES     = 4096;
  localparam int ENTRIES_PER_GROUP = 128;
  localparam int ADDR_W            = $clog2(TABLE_ENTRIES);
  localparam int ENT_W             = $clog2(ENTRIES_PER_GROUP);
  localparam int GRP_W             = ADDR_W - ENT_W;
  localparam int NUM_GROUPS        = TABLE_ENTRIES / ENTRIES_PER_GROUP;
  localparam int LINK_W            = 32;
  localparam int GC_W              = 6;
  localparam int TC_W              = 13;
  localparam int MODE_W            = 2;
  localparam int STATUS_W          = 2;
  localparam int PADDR_W           = 4;

  localparam logic [LINK_W-1:0] LINK_FREE = 32'h0000_0000;
  localparam logic [LINK_W-1:0] LINK_END  = 32'hFFFF_FFFF;

  localparam logic [MODE_W-1:0] MODE_SET  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GET  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIND = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNMOUNTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOFREE    = 2'd3;

  localparam logic [1:0] REG_MOUNTED        = 2'd0;
  localparam logic [1:0] REG_TOTAL_CLUSTERS = 2'd1;
  localparam logic [1:0] REG_GROUP_COUNT    = 2'd2;

  typedef struct packed {
    logic            mounted;
    logic [TC_W-1:0] total_clusters;
    logic [GC_W-1:0] group_count;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [LINK_W-1:0] wdata;
  } ram_req_t;

endpackage

>>> rtl/cluster_link_table_allocator_top.sv
// ----------------------------------------------------------------------------
// cluster_link_table_allocator_top: cluster link table with next-fit search
// Input transactions carry mode, cluster_index and link_value; each one
// produces exactly one output transaction with status and data. Modes are
// set link, get link and find free cluster. Configuration (mounted,
// total_clusters, group_count) is written over the APB port at byte
// addresses 0, 4 and 8 and is read back the same way; pready is always high.
// Find-free first reduces the start group modulo group_count by repeated
// subtraction, then reads the link memory one entry per cycle through its
// single port. One transaction is in work at a time; in_ready is high only
// while the sequencer is idle. After reset the sequencer clears the
// 4096-entry memory, one entry per cycle, marking entry 0 as end of chain;
// in_ready stays low meanwhile while configuration writes are still taken.
// A finished result sits in an output register; while out_ready is low the
// next transaction can still be accepted, and its result waits until the
// register frees.
// ----------------------------------------------------------------------------
module cluster_link_table_allocator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [clt_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [clt_pkg::MODE_W-1:0]    mode,
  input  logic [clt_pkg::ADDR_W-1:0]    cluster_index,
  input  logic [clt_pkg::LINK_W-1:0]    link_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [clt_pkg::STATUS_W-1:0]  status,
  output logic [clt_pkg::LINK_W-1:0]    data
);
  import clt_pkg::*;

  cfg_t              cfg;
  ram_req_t          ram_req;
  logic [LINK_W-1:0] ram_rdata;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_MOUNTED:        cfg.mounted        <= pwdata[0];
        REG_TOTAL_CLUSTERS: cfg.total_clusters <= pwdata[TC_W-1:0];
        REG_GROUP_COUNT:    cfg.group_count    <= pwdata[GC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MOUNTED:        prdata = {31'b0, cfg.mounted};
      REG_TOTAL_CLUSTERS: prdata = {{(32-TC_W){1'b0}}, cfg.total_clusters};
      REG_GROUP_COUNT:    prdata = {{(32-GC_W){1'b0}}, cfg.group_count};
      default:            prdata = '0;
    endcase
  end

  clt_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .cluster_index (cluster_index),
    .link_value    (link_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .data          (data),
    .ram_req       (ram_req),
    .ram_rdata     (ram_rdata)
  );

  clt_link_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

endmodule

>>> rtl/clt_link_ram.sv
// ----------------------------------------------------------------------------
// clt_link_ram: link table storage
// Single-port memory of link entries with a registered read port.
// ----------------------------------------------------------------------------
module clt_link_ram (
  input  logic                     clk,
  input  clt_pkg::ram_req_t        req,
  output logic [clt_pkg::LINK_W-1:0] rdata
);
  import clt_pkg::*;

  logic [LINK_W-1:0] mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

>>> rtl/clt_ctrl.sv
// ----------------------------------------------------------------------------
// clt_ctrl: operation sequencer for the cluster link table
// Clears the table after reset, runs set and get, and walks the table one
// entry per cycle for the next-fit free cluster search.
// ----------------------------------------------------------------------------
module clt_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  clt_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [clt_pkg::MODE_W-1:0]   mode,
  input  logic [clt_pkg::ADDR_W-1:0]   cluster_index,
  input  logic [clt_pkg::LINK_W-1:0]   link_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [clt_pkg::STATUS_W-1:0] status,
  output logic [clt_pkg::LINK_W-1:0]   data,
  output clt_pkg::ram_req_t            ram_req,
  input  logic [clt_pkg::LINK_W-1:0]   ram_rdata
);
  import clt_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_GET   = 7'b0001000,
    S_MOD   = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t              state;
  logic [ADDR_W-1:0]   clr_addr;
  logic [MODE_W-1:0]   op_mode;
  logic [ADDR_W-1:0]   op_index;
  logic [LINK_W-1:0]   op_value;
  logic [STATUS_W-1:0] res_status;
  logic [LINK_W-1:0]   res_data;
  logic [STATUS_W-1:0] out_status;
  logic [LINK_W-1:0]   out_data;
  logic [GRP_W-1:0]    lfg;
  logic [GC_W-1:0]     grp;
  logic [ENT_W-1:0]    ent;
  logic [GC_W-1:0]     groups_left;
  logic                issuing;
  logic                chk_valid;
  logic [ADDR_W-1:0]   chk_idx;

  logic                idx_ok;
  logic                last_grp;
  logic [ENT_W-1:0]    tc_rem;
  logic [ENT_W-1:0]    ent_lim;
  logic                grp_in_table;
  logic [GC_W-1:0]     grp_inc;
  logic [GC_W-1:0]     grp_next;
  logic [ADDR_W-1:0]   scan_addr;
  logic                hit;
  logic                out_load;

  assign in_ready = (state == S_IDLE);
  assign status   = out_status;
  assign data     = out_data;

  assign idx_ok       = {1'b0, op_index[ADDR_W-1:ENT_W]} < cfg.group_count;
  assign last_grp     = (grp == (cfg.group_count - GC_W'(1)));
  assign tc_rem       = cfg.total_clusters[ENT_W-1:0];
  assign grp_in_table = grp < GC_W'(NUM_GROUPS);
  assign grp_inc      = grp + GC_W'(1);
  assign grp_next     = (grp_inc == cfg.group_count) ? '0 : grp_inc;
  assign scan_addr    = {grp[GRP_W-1:0], ent};
  assign hit          = chk_valid && (ram_rdata == LINK_FREE);
  assign out_load     = (state == S_RESP) && (!out_valid || out_ready);

  // A zero remainder means the final group is full.
  always_comb begin
    if (!last_grp) begin
      ent_lim = '1;
    end else if (tc_rem == '0) begin
      ent_lim = '1;
    end else begin
      ent_lim = tc_rem - ENT_W'(1);
    end
  end

  always_comb begin
    ram_req.we    = 1'b0;
    ram_req.addr  = op_index;
    ram_req.wdata = op_value;
    case (state)
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.addr  = clr_addr;
        ram_req.wdata = (clr_addr == '0) ? LINK_END : LINK_FREE;
      end
      S_EXEC: begin
        ram_req.we = cfg.mounted && (op_mode == MODE_SET) && idx_ok;
      end
      S_SCAN: begin
        ram_req.addr = scan_addr;
      end
      default: begin
        ram_req.we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      lfg       <= '0;
      issuing   <= 1'b0;
      chk_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_mode  <= mode;
            op_index <= cluster_index;
            op_value <= link_value;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (!cfg.mounted) begin
            res_status <= ST_UNMOUNTED;
            res_data   <= LINK_END;
            state      <= S_RESP;
          end else begin
            case (op_mode)
              MODE_SET: begin
                if (idx_ok) begin
                  res_status <= ST_OK;
                  res_data   <= '0;
                end else begin
                  res_status <= ST_RANGE;
                  res_data   <= LINK_END;
                end
                state <= S_RESP;
              end
              MODE_GET: begin
                if (idx_ok) begin
                  state <= S_GET;
                end else begin
                  res_status <= ST_RANGE;
                  res_data   <= LINK_END;
                  state      <= S_RESP;
                end
              end
              MODE_FIND: begin
                if (cfg.group_count == '0) begin
                  res_status <= ST_NOFREE;
                  res_data   <= LINK_END;
                  state      <= S_RESP;
                end else begin
                  grp   <= {1'b0, lfg};
                  state <= S_MOD;
                end
              end
              default: begin
                res_status <= ST_RANGE;
                res_data   <= LINK_END;
                state      <= S_RESP;
              end
            endcase
          end
        end
        S_GET: begin
          res_status <= ST_OK;
          res_data   <= ram_rdata;
          state      <= S_RESP;
        end
        S_MOD: begin
          // A stale start group is reduced by repeated subtraction.
          if (grp >= cfg.group_count) begin
            grp <= grp - cfg.group_count;
          end else begin
            ent         <= '0;
            groups_left <= cfg.group_count;
            issuing     <= 1'b1;
            chk_valid   <= 1'b0;
            state       <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Reads are issued one entry ahead of the compare on returned data.
          chk_idx <= scan_addr;
          if (hit) begin
            res_status <= ST_OK;
            res_data   <= LINK_W'(chk_idx);
            lfg        <= chk_idx[ADDR_W-1:ENT_W];
            issuing    <= 1'b0;
            chk_valid  <= 1'b0;
            state      <= S_RESP;
          end else begin
            chk_valid <= issuing && grp_in_table;
            if (issuing) begin
              if (!grp_in_table || (ent == ent_lim)) begin
                ent         <= '0;
                grp         <= grp_next;
                groups_left <= groups_left - GC_W'(1);
                if (groups_left == GC_W'(1)) begin
                  issuing <= 1'b0;
                end
              end else begin
                ent <= ent + ENT_W'(1);
              end
            end else if (!chk_valid) begin
              res_status <= ST_NOFREE;
              res_data   <= LINK_END;
              state      <= S_RESP;
            end
          end
        end
        S_RESP: begin
          if (out_load) begin
            out_status <= res_status;
            out_data   <= res_data;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !ram_req.we)
    else $error("link table written during free cluster search");

  a_found_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && hit) |=> (res_status == ST_OK && res_data < TABLE_ENTRIES))
    else $error("found cluster index outside the table");

  a_unmounted: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && !cfg.mounted) |=> (res_status == ST_UNMOUNTED))
    else $error("operation on unmounted table did not fail");

  a_lfg_on_hit: assert property (@(posedge clk) disable iff (rst)
    !$stable(lfg) |-> $past(state == S_SCAN && hit))
    else $error("last found group changed without a successful search");

  a_result_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RESP))
    else $error("result presented outside the response step");

endmodule
